// ----- rtl/hbm_pkg.sv -----
// Shared types and codes for the heartbeat membership table.
package hbm_pkg;

   localparam int MAX_RESULTS = 32;
   localparam int RESULT_W = 6;

   typedef enum logic [1:0] {
      OP_MERGE  = 2'd0,
      OP_TICK   = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_DUMP   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_ADDED     = 4'd0,
      ST_UPDATED   = 4'd1,
      ST_STALE     = 4'd2,
      ST_FULL      = 4'd3,
      ST_TICK_DONE = 4'd4,
      ST_HIT       = 4'd5,
      ST_RING_EMPTY = 4'd6,
      ST_ENTRY     = 4'd7,
      ST_NONE_LIVE = 4'd8
   } status_type;

   typedef struct packed {
      logic [31:0]        ip;
      logic [15:0]        port;
      logic [31:0]        beat;
      logic signed [31:0] start;
      logic [31:0]        seen;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // per-entry verdicts from the evaluation unit
   typedef struct packed {
      logic match;
      logic newer;
      logic dead;
      logic live;
      logic on_ring;
      logic ge_key;
      logic lt_min;
      logic lt_ge;
   } eval_type;

endpackage

// ----- rtl/hbm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [AW-1:0]            waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [AW-1:0]            raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/hbm_eval.sv -----
// Entry evaluation unit: key match, age and ring compares for one table entry.
module hbm_eval (
   input  hbm_pkg::entry_type  entry,
   input  logic [31:0]         req_ip,
   input  logic [15:0]         req_port,
   input  logic [31:0]         req_beat,
   input  logic signed [31:0]  req_key,
   input  logic [31:0]         now,
   input  logic [31:0]         fail_timeout,
   input  logic [31:0]         remove_timeout,
   input  logic signed [31:0]  min_start,
   input  logic signed [31:0]  ge_start,
   output hbm_pkg::eval_type   verdict
);
   logic [32:0] remove_age;
   logic [32:0] fail_age;

   always_comb begin
      remove_age = {1'b0, entry.seen} + {1'b0, remove_timeout};
      fail_age   = {1'b0, entry.seen} + {1'b0, fail_timeout};
      verdict.match   = (entry.ip == req_ip) && (entry.port == req_port);
      verdict.newer   = req_beat > entry.beat;
      verdict.dead    = remove_age < {1'b0, now};
      verdict.live    = fail_age > {1'b0, now};
      verdict.on_ring = entry.start != 32'hFFFF_FFFF;
      verdict.ge_key  = entry.start >= req_key;
      verdict.lt_min  = entry.start < min_start;
      verdict.lt_ge   = entry.start < ge_start;
   end
endmodule

// ----- rtl/heartbeat_membership_table_unit.sv -----
// Top level: membership table with a scan sequencer over one entry RAM.
// Merge, lookup and dump scan the stored entries, each one read and then evaluated;
// tick scans them the same way, then removes each expired member in a purge pass.
// One item at a time: the next word is taken once the sequencer is idle.
// Dump results leave one per word as the output register drains.
// Synchronous reset empties the table and clears the clock; no RAM clearing.
module heartbeat_membership_table_unit #(
   parameter int MAX_MEMBERS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // operation
   // node_ip, node_port, beat_count, ring_start, time_now, lookup_key
   input  logic [175:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [3:0]   rsp_tuser,   // status
   // out_ip, out_port, out_beat, out_start, removed_count, zero pad
   output logic [119:0] rsp_tdata,
   output logic         rsp_tlast,   // last
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);
   localparam int AW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
   localparam int CW = $clog2(MAX_MEMBERS + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_MEMBERS);
   localparam logic [hbm_pkg::RESULT_W-1:0] RESULT_LIMIT =
      hbm_pkg::RESULT_W'(hbm_pkg::MAX_RESULTS);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,
      S_EVAL  = 6'b000100,
      S_PURGE = 6'b001000,
      S_MOVE  = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] fail_ff, remove_ff, clock_now_ff, clock_now_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in, removed_ff, removed_in;
   logic [hbm_pkg::RESULT_W-1:0] cnt_ff, cnt_in;

   hbm_pkg::op_type op_ff;
   logic [31:0] ip_ff, beat_ff;
   logic [15:0] port_ff;
   logic signed [31:0] start_ff, key_ff;

   logic found_ff, found_in;
   hbm_pkg::status_type mstat_ff, mstat_in;
   logic any_ff, any_in, ge_any_ff, ge_any_in, pend_ff, pend_in;
   hbm_pkg::entry_type min_ff, min_in, ge_ff, ge_in, pend_e_ff, pend_e_in;

   logic rsp_valid_ff, rsp_valid_in, load;
   hbm_pkg::status_type o_stat_ff, o_stat_in;
   hbm_pkg::entry_type o_e_ff, o_e_in;
   logic [hbm_pkg::RESULT_W-1:0] o_rem_ff, o_rem_in;
   logic o_last_ff, o_last_in;

   // tick removal: expired flags by original slot, original slot of each entry
   logic [MAX_MEMBERS-1:0] dead_ff, dead_in;
   logic [AW-1:0] tag_ff [MAX_MEMBERS];
   logic tag_we;
   logic [AW-1:0] tag_waddr, tag_wdata;
   logic [AW-1:0] hole_ff, hole_in, kill_tag, hole;

   logic we;
   logic [AW-1:0] waddr, raddr;
   hbm_pkg::entry_type wdata, rdata;
   logic [hbm_pkg::ENTRY_W-1:0] rdata_bits;
   hbm_pkg::eval_type v;
   logic out_free, accept;
   logic [CW-1:0] last_pos;

   hbm_ram #(.WIDTH(hbm_pkg::ENTRY_W), .DEPTH(MAX_MEMBERS)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata_bits)
   );
   assign rdata = hbm_pkg::entry_type'(rdata_bits);

   hbm_eval u_eval (
      .entry          (rdata),
      .req_ip         (ip_ff),
      .req_port       (port_ff),
      .req_beat       (beat_ff),
      .req_key        (key_ff),
      .now            (clock_now_ff),
      .fail_timeout   (fail_ff),
      .remove_timeout (remove_ff),
      .min_start      (min_ff.start),
      .ge_start       (ge_ff.start),
      .verdict        (v)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_pos   = count_ff - 1'b1;

   // lowest pending expired original slot, and where that entry sits now
   always_comb begin
      kill_tag = '0;
      for (int i = MAX_MEMBERS - 1; i >= 0; i--) begin
         if (dead_ff[i]) begin
            kill_tag = AW'(i);
         end
      end
      hole = '0;
      for (int i = 0; i < MAX_MEMBERS; i++) begin
         if (tag_ff[i] == kill_tag && CW'(i) < count_ff) begin
            hole = AW'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      clock_now_in = clock_now_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      removed_in   = removed_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      mstat_in     = mstat_ff;
      any_in       = any_ff;
      ge_any_in    = ge_any_ff;
      pend_in      = pend_ff;
      min_in       = min_ff;
      ge_in        = ge_ff;
      pend_e_in    = pend_e_ff;
      dead_in      = dead_ff;
      hole_in      = hole_ff;
      tag_we       = 1'b0;
      tag_waddr    = idx_ff[AW-1:0];
      tag_wdata    = idx_ff[AW-1:0];
      load         = 1'b0;
      o_stat_in    = o_stat_ff;
      o_e_in       = o_e_ff;
      o_rem_in     = o_rem_ff;
      o_last_in    = o_last_ff;
      we           = 1'b0;
      waddr        = idx_ff[AW-1:0];
      wdata        = rdata;
      raddr        = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in     = '0;
               removed_in = '0;
               cnt_in     = '0;
               found_in   = 1'b0;
               any_in     = 1'b0;
               ge_any_in  = 1'b0;
               pend_in    = 1'b0;
               dead_in    = '0;
               if (hbm_pkg::op_type'(req_tuser) == hbm_pkg::OP_TICK &&
                   req_tdata[143:112] > clock_now_ff) begin
                  clock_now_in = req_tdata[143:112];
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (idx_ff >= count_ff ||
                (op_ff == hbm_pkg::OP_DUMP && cnt_ff == RESULT_LIMIT)) begin
               state_in = (op_ff == hbm_pkg::OP_TICK) ? S_PURGE : S_FIN;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            unique case (op_ff)
               hbm_pkg::OP_MERGE: begin
                  if (v.match) begin
                     found_in = 1'b1;
                     if (v.newer) begin
                        we = 1'b1;
                        wdata.beat  = beat_ff;
                        wdata.start = start_ff;
                        wdata.seen  = clock_now_ff;
                        mstat_in = hbm_pkg::ST_UPDATED;
                     end else begin
                        mstat_in = hbm_pkg::ST_STALE;
                     end
                     state_in = S_FIN;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_READ;
                  end
               end
               hbm_pkg::OP_TICK: begin
                  dead_in[idx_ff[AW-1:0]] = v.dead;
                  tag_we   = 1'b1;
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
               hbm_pkg::OP_LOOKUP: begin
                  if (v.on_ring) begin
                     any_in = 1'b1;
                     if (!any_ff || v.lt_min) begin
                        min_in = rdata;
                     end
                     if (v.ge_key && (!ge_any_ff || v.lt_ge)) begin
                        ge_in     = rdata;
                        ge_any_in = 1'b1;
                     end
                  end
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
               hbm_pkg::OP_DUMP: begin
                  // one live word is held back so the final one can carry tlast
                  if (!v.live) begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_READ;
                  end else if (!pend_ff) begin
                     pend_in   = 1'b1;
                     pend_e_in = rdata;
                     cnt_in    = cnt_ff + 1'b1;
                     idx_in    = idx_ff + 1'b1;
                     state_in  = S_READ;
                  end else if (out_free) begin
                     load      = 1'b1;
                     o_stat_in = hbm_pkg::ST_ENTRY;
                     o_e_in    = pend_e_ff;
                     o_rem_in  = '0;
                     o_last_in = 1'b0;
                     pend_e_in = rdata;
                     cnt_in    = cnt_ff + 1'b1;
                     idx_in    = idx_ff + 1'b1;
                     state_in  = S_READ;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_PURGE: begin
            // expired members go in their original order
            if (dead_ff == '0) begin
               state_in = S_FIN;
            end else begin
               dead_in[kill_tag] = 1'b0;
               if (hole == last_pos[AW-1:0]) begin
                  count_in   = last_pos;
                  removed_in = removed_ff + 1'b1;
               end else begin
                  // fetch the last entry to refill the freed slot
                  raddr    = last_pos[AW-1:0];
                  hole_in  = hole;
                  state_in = S_MOVE;
               end
            end
         end
         S_MOVE: begin
            we         = 1'b1;
            waddr      = hole_ff;
            wdata      = rdata;
            tag_we     = 1'b1;
            tag_waddr  = hole_ff;
            tag_wdata  = tag_ff[last_pos[AW-1:0]];
            count_in   = last_pos;
            removed_in = removed_ff + 1'b1;
            state_in   = S_PURGE;
         end
         S_FIN: begin
            if (out_free) begin
               load      = 1'b1;
               o_e_in    = '0;
               o_rem_in  = '0;
               o_last_in = 1'b1;
               unique case (op_ff)
                  hbm_pkg::OP_MERGE: begin
                     if (found_ff) begin
                        o_stat_in = mstat_ff;
                     end else if (count_ff >= FULL_COUNT) begin
                        o_stat_in = hbm_pkg::ST_FULL;
                     end else begin
                        we    = 1'b1;
                        waddr = count_ff[AW-1:0];
                        wdata = '{ip: ip_ff, port: port_ff, beat: beat_ff,
                                  start: start_ff, seen: clock_now_ff};
                        count_in  = count_ff + 1'b1;
                        o_stat_in = hbm_pkg::ST_ADDED;
                     end
                  end
                  hbm_pkg::OP_TICK: begin
                     o_stat_in = hbm_pkg::ST_TICK_DONE;
                     o_rem_in  = hbm_pkg::RESULT_W'(removed_ff);
                  end
                  hbm_pkg::OP_LOOKUP: begin
                     if (!any_ff) begin
                        o_stat_in = hbm_pkg::ST_RING_EMPTY;
                     end else begin
                        o_stat_in   = hbm_pkg::ST_HIT;
                        o_e_in.ip   = ge_any_ff ? ge_ff.ip : min_ff.ip;
                        o_e_in.port = ge_any_ff ? ge_ff.port : min_ff.port;
                     end
                  end
                  hbm_pkg::OP_DUMP: begin
                     if (pend_ff) begin
                        o_stat_in    = hbm_pkg::ST_ENTRY;
                        o_e_in       = pend_e_ff;
                     end else begin
                        o_stat_in = hbm_pkg::ST_NONE_LIVE;
                     end
                  end
                  default: o_stat_in = hbm_pkg::ST_NONE_LIVE;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fail_ff      <= 32'd1000;
         remove_ff    <= 32'd2000;
         clock_now_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_now_ff <= clock_now_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && !csr_index) begin
            fail_ff <= csr_wdata;
         end
         if (csr_we && csr_index) begin
            remove_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      removed_ff <= removed_in;
      cnt_ff     <= cnt_in;
      found_ff   <= found_in;
      mstat_ff   <= mstat_in;
      any_ff     <= any_in;
      ge_any_ff  <= ge_any_in;
      pend_ff    <= pend_in;
      min_ff     <= min_in;
      ge_ff      <= ge_in;
      pend_e_ff  <= pend_e_in;
      dead_ff    <= dead_in;
      hole_ff    <= hole_in;
      o_stat_ff  <= o_stat_in;
      o_e_ff     <= o_e_in;
      o_rem_ff   <= o_rem_in;
      o_last_ff  <= o_last_in;
      if (tag_we) begin
         tag_ff[tag_waddr] <= tag_wdata;
      end
      if (accept) begin
         op_ff    <= hbm_pkg::op_type'(req_tuser);
         ip_ff    <= req_tdata[31:0];
         port_ff  <= req_tdata[47:32];
         beat_ff  <= req_tdata[79:48];
         start_ff <= req_tdata[111:80];
         key_ff   <= req_tdata[175:144];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = o_stat_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {2'b00, o_rem_ff, o_e_ff.start, o_e_ff.beat, o_e_ff.port, o_e_ff.ip};
endmodule

// ----- test/tb_heartbeat_membership_table_unit.sv -----
// Self-checking testbench for the heartbeat membership table unit.
module tb_heartbeat_membership_table_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 32;

   typedef struct packed {
      hbm_pkg::op_type op;
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] beat;
      logic [31:0] start;
      logic [31:0] tnow;
      logic [31:0] key;
   } gossip_word;

   typedef struct packed {
      hbm_pkg::status_type status;
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] beat;
      logic [31:0] start;
      logic [5:0]  removed;
      logic        last;
   } reply_word;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = '0;
   logic [175:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [3:0]   rsp_tuser;
   logic [119:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic         csr_index = 1'b0;
   logic [31:0]  csr_wdata = '0;

   heartbeat_membership_table_unit dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [31:0] m_ip[TABLE_DEPTH];
   logic [15:0] m_port[TABLE_DEPTH];
   logic [31:0] m_beat[TABLE_DEPTH];
   logic [31:0] m_start[TABLE_DEPTH];
   logic [31:0] m_seen[TABLE_DEPTH];
   int          m_count;
   logic [31:0] m_clock;
   logic [31:0] m_clock_hint;
   logic [31:0] live_age, drop_age;

   gossip_word  pending_words[$];
   reply_word   expected_replies[$];
   int          errors, words_sent, replies_seen, hit_count, removal_count;
   logic        tx_busy;

   function automatic void expect_reply(reply_word r);
      expected_replies = {expected_replies, r};
   endfunction

   function automatic void queue_word(gossip_word w);
      pending_words = {pending_words, w};
   endfunction

   function automatic reply_word blank(hbm_pkg::status_type s);
      reply_word r;
      r = '0;
      r.status = s;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void copy_slot(int dst, int src);
      m_ip[dst] = m_ip[src];
      m_port[dst] = m_port[src];
      m_beat[dst] = m_beat[src];
      m_start[dst] = m_start[src];
      m_seen[dst] = m_seen[src];
   endfunction

   function automatic void predict_membership(gossip_word w);
      reply_word r;
      bit        dead[TABLE_DEPTH];
      int        tag[TABLE_DEPTH];
      int        n, removed, best_ge, best_min, cnt;
      bit        found, any, any_ge;
      n = m_count;
      case (w.op)
         hbm_pkg::OP_MERGE: begin
            found = 0;
            for (int i = 0; i < n; i++)
               if (!found && m_ip[i] == w.ip && m_port[i] == w.port) begin
                  found = 1;
                  if (w.beat > m_beat[i]) begin
                     m_beat[i] = w.beat;
                     m_start[i] = w.start;
                     m_seen[i] = m_clock;
                     expect_reply(blank(hbm_pkg::ST_UPDATED));
                  end else begin
                     expect_reply(blank(hbm_pkg::ST_STALE));
                  end
               end
            if (!found) begin
               if (n >= TABLE_DEPTH) begin
                  expect_reply(blank(hbm_pkg::ST_FULL));
               end else begin
                  m_ip[n] = w.ip;
                  m_port[n] = w.port;
                  m_beat[n] = w.beat;
                  m_start[n] = w.start;
                  m_seen[n] = m_clock;
                  m_count = n + 1;
                  expect_reply(blank(hbm_pkg::ST_ADDED));
               end
            end
         end
         hbm_pkg::OP_TICK: begin
            removed = 0;
            if (w.tnow > m_clock) m_clock = w.tnow;
            for (int i = 0; i < n; i++) begin
               dead[i] = ({1'b0, m_seen[i]} + {1'b0, drop_age}) < {1'b0, m_clock};
               tag[i] = i;
            end
            for (int k = 0; k < n; k++) begin
               if (dead[k]) begin
                  found = 0;
                  for (int i = 0; i < m_count; i++)
                     if (!found && tag[i] == k) begin
                        found = 1;
                        copy_slot(i, m_count - 1);
                        tag[i] = tag[m_count - 1];
                        m_count--;
                        removed++;
                     end
               end
            end
            removal_count += removed;
            r = blank(hbm_pkg::ST_TICK_DONE);
            r.removed = removed[5:0];
            expect_reply(r);
         end
         hbm_pkg::OP_LOOKUP: begin
            any = 0;
            any_ge = 0;
            best_ge = 0;
            best_min = 0;
            for (int i = 0; i < n; i++) begin
               if (m_start[i] != '1) begin
                  if (!any || $signed(m_start[i]) < $signed(m_start[best_min])) best_min = i;
                  any = 1;
                  if ($signed(m_start[i]) >= $signed(w.key) &&
                      (!any_ge || $signed(m_start[i]) < $signed(m_start[best_ge]))) begin
                     best_ge = i;
                     any_ge = 1;
                  end
               end
            end
            if (!any) begin
               expect_reply(blank(hbm_pkg::ST_RING_EMPTY));
            end else begin
               if (any_ge) best_min = best_ge;
               r = blank(hbm_pkg::ST_HIT);
               r.ip = m_ip[best_min];
               r.port = m_port[best_min];
               expect_reply(r);
               hit_count++;
            end
         end
         default: begin
            cnt = 0;
            for (int i = 0; i < n && cnt < hbm_pkg::MAX_RESULTS; i++)
               if (({1'b0, m_seen[i]} + {1'b0, live_age}) > {1'b0, m_clock}) begin
                  r = '0;
                  r.status = hbm_pkg::ST_ENTRY;
                  r.ip = m_ip[i];
                  r.port = m_port[i];
                  r.beat = m_beat[i];
                  r.start = m_start[i];
                  expect_reply(r);
                  cnt++;
               end
            if (cnt == 0) expect_reply(blank(hbm_pkg::ST_NONE_LIVE));
            else expected_replies[$].last = 1'b1;
         end
      endcase
   endfunction

   // sender: drives at the falling edge, random gaps between words
   int tx_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && tx_busy) begin
            // word still waiting for acceptance
         end else if (tx_gap > 0) begin
            req_tvalid <= 1'b0;
            tx_gap <= tx_gap - 1;
         end else if (pending_words.size() > 0) begin
            gossip_word w;
            w = pending_words.pop_front();
            predict_membership(w);
            req_tvalid <= 1'b1;
            req_tuser <= w.op;
            req_tdata <= {w.key, w.tnow, w.start, w.beat, w.port, w.ip};
            tx_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                      ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // tracks whether the driven word is still outstanding
   always @(posedge clock) begin
      if (reset) tx_busy <= 1'b0;
      else if (req_tvalid && req_tready) begin
         tx_busy <= 1'b0;
         words_sent++;
      end else if (req_tvalid) tx_busy <= 1'b1;
   end

   // receiver backpressure
   int rx_stall = 0;
   always @(negedge clock) begin
      if (rx_stall > 0) begin
         rsp_tready <= 1'b0;
         rx_stall <= rx_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 9) < 3)
            rx_stall <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         reply_word e;
         replies_seen++;
         if (expected_replies.size() == 0) begin
            $error("unexpected reply word status=%0d", rsp_tuser);
            errors++;
         end else begin
            e = expected_replies.pop_front();
            if (rsp_tuser != e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_tuser); errors++;
            end
            if (rsp_tdata[31:0] != e.ip) begin
               $error("out_ip exp %h got %h", e.ip, rsp_tdata[31:0]); errors++;
            end
            if (rsp_tdata[47:32] != e.port) begin
               $error("out_port exp %h got %h", e.port, rsp_tdata[47:32]); errors++;
            end
            if (rsp_tdata[79:48] != e.beat) begin
               $error("out_beat exp %h got %h", e.beat, rsp_tdata[79:48]); errors++;
            end
            if (rsp_tdata[111:80] != e.start) begin
               $error("out_start exp %h got %h", e.start, rsp_tdata[111:80]); errors++;
            end
            if (rsp_tdata[117:112] != e.removed) begin
               $error("removed_count exp %0d got %0d", e.removed, rsp_tdata[117:112]);
               errors++;
            end
            if (rsp_tlast != e.last) begin
               $error("last exp %0b got %0b", e.last, rsp_tlast); errors++;
            end
         end
      end
   end

   function automatic gossip_word make_word(hbm_pkg::op_type op, logic [31:0] ip,
                                             logic [15:0] port,
                                             logic [31:0] beat, logic [31:0] start,
                                             logic [31:0] tnow, logic [31:0] key);
      gossip_word w;
      w.op = op; w.ip = ip; w.port = port; w.beat = beat;
      w.start = start; w.tnow = tnow; w.key = key;
      return w;
   endfunction

   function automatic logic [31:0] rand32();
      return $urandom();
   endfunction

   // a phase of well-formed gossip traffic over a small pool of members
   function automatic void queue_random_phase(int count, int pool);
      gossip_word w;
      int sel, id;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         id = $urandom_range(0, pool - 1);
         w = make_word(hbm_pkg::OP_MERGE, 32'h0a000000 + id, 16'(7000 + id % 3), rand32(),
                       ($urandom_range(0, 4) == 0) ? 32'hffffffff : rand32(), rand32(), rand32());
         if ($urandom_range(0, 5) == 0) w.beat = $urandom_range(0, 20);
         if ($urandom_range(0, 9) == 0) w.ip = rand32();
         if ($urandom_range(0, 3) == 0) w.port = 16'($urandom());
         if (sel < 50) w.op = hbm_pkg::OP_MERGE;
         else if (sel < 68) begin
            w.op = hbm_pkg::OP_TICK;
            w.tnow = ($urandom_range(0, 9) == 0) ? rand32() : m_clock_hint + $urandom_range(0, 1500);
            m_clock_hint = (w.tnow > m_clock_hint) ? w.tnow : m_clock_hint;
         end else if (sel < 88) w.op = hbm_pkg::OP_LOOKUP;
         else w.op = hbm_pkg::OP_DUMP;
         queue_word(w);
      end
   endfunction

   task automatic wait_drained();
      int guard;
      guard = 0;
      while ((pending_words.size() > 0 || req_tvalid || expected_replies.size() > 0)
             && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (150) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == 1'b0) live_age = val;
      else drop_age = val;
   endtask

   initial begin
      errors = 0; words_sent = 0; replies_seen = 0; hit_count = 0; removal_count = 0;
      m_count = 0; m_clock = '0; m_clock_hint = '0;
      live_age = 32'd1000; drop_age = 32'd2000;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table cases, field extremes, stale/update, wrap lookup
      queue_word(make_word(hbm_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 32'h80000000));
      queue_word(make_word(hbm_pkg::OP_DUMP, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(hbm_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(hbm_pkg::OP_MERGE, 32'hffffffff, 16'hffff, 32'hffffffff,
                           32'h7fffffff, 32'hffffffff, 32'hffffffff));
      queue_word(make_word(hbm_pkg::OP_MERGE, 0, 0, 0, 32'hffffffff, 0, 0));
      queue_word(make_word(hbm_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(hbm_pkg::OP_MERGE, 0, 0, 0, 32'h80000000, 0, 0));
      queue_word(make_word(hbm_pkg::OP_MERGE, 0, 0, 5, 32'h80000000, 0, 0));
      queue_word(make_word(hbm_pkg::OP_MERGE, 5, 1, 3, 32'h80000000, 0, 0));
      queue_word(make_word(hbm_pkg::OP_MERGE, 6, 1, 3, 32'hfffffff0, 0, 0));
      queue_word(make_word(hbm_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 32'h80000000));
      queue_word(make_word(hbm_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 32'h7fffffff));
      queue_word(make_word(hbm_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 32'hfffffff1));
      queue_word(make_word(hbm_pkg::OP_DUMP, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(hbm_pkg::OP_TICK, 0, 0, 0, 0, 1500, 0));
      queue_word(make_word(hbm_pkg::OP_TICK, 0, 0, 0, 0, 100, 0));
      queue_word(make_word(hbm_pkg::OP_DUMP, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(hbm_pkg::OP_TICK, 0, 0, 0, 0, 2001, 0));
      queue_word(make_word(hbm_pkg::OP_TICK, 0, 0, 0, 0, 32'hffffffff, 0));
      queue_word(make_word(hbm_pkg::OP_DUMP, 0, 0, 0, 0, 0, 0));
      wait_drained();

      // fill past capacity so the full case and long dumps appear
      for (int i = 0; i < TABLE_DEPTH + 2; i++)
         queue_word(make_word(hbm_pkg::OP_MERGE, rand32(), 16'($urandom()), rand32(),
                              rand32(), 0, 0));
      queue_word(make_word(hbm_pkg::OP_DUMP, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(hbm_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, rand32()));
      wait_drained();

      // timeouts at extremes; clock is saturated, so with zero limits no member reads as live
      write_csr(1'b0, 32'hffffffff);
      write_csr(1'b1, 32'hffffffff);
      m_clock_hint = m_clock;
      queue_random_phase(40, 40);
      wait_drained();
      write_csr(1'b0, 32'd0);
      write_csr(1'b1, 32'd0);
      queue_word(make_word(hbm_pkg::OP_DUMP, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(hbm_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(hbm_pkg::OP_DUMP, 0, 0, 0, 0, 0, 0));
      wait_drained();

      // the table clock is stuck high now; reset can't be reused, so use mid-range timeouts
      // for a phase, then huge ones, then the defaults, where churn is visible relative to wrap-free sums
      write_csr(1'b0, 32'd400);
      write_csr(1'b1, 32'd900);
      queue_random_phase(130, 24);
      wait_drained();
      write_csr(1'b0, 32'hfffff000);
      write_csr(1'b1, 32'hffffff00);
      queue_random_phase(130, 48);
      wait_drained();
      write_csr(1'b0, 32'd1000);
      write_csr(1'b1, 32'd2000);
      queue_random_phase(120, 12);
      wait_drained();

      $display("Covered %0d words, %0d replies, %0d ring hits, %0d members aged out.",
               words_sent, replies_seen, hit_count, removal_count);
      if (errors == 0 && expected_replies.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
